>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; the including file supplies clock and reset names
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define PPSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppsf assertion failed");

// condition that must never be seen while out of reset
`define PPSF_NEVER(lbl, clk, rst_n, cond) \
  `PPSF_ASSERT(lbl, clk, rst_n, !(cond))

`endif

>>> rtl/core/ppsf_pkg.sv
// shared types and constants of the preamble parity symbol framer
// no dependencies
`default_nettype none

package ppsf_pkg;

  localparam int unsigned DUR_W        = 20;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PRE_W        = 6;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned MAX_PREAMBLE = 32;
  // queue depth, must be a power of two
  localparam int unsigned QUEUE_DEPTH  = 2;

  // symbol kinds
  localparam logic [KIND_W-1:0] KIND_LONG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GAP   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER   = 3'd4;

  // reset values
  localparam logic [DUR_W-1:0]  RST_SHORT_LEN = 20'd800;
  localparam logic [DUR_W-1:0]  RST_LONG_LEN  = 20'd4000;
  localparam logic [DUR_W-1:0]  RST_GAP_LEN   = 20'd200000;
  localparam logic [PRE_W-1:0]  RST_PRE_COUNT = 6'd10;
  localparam logic [BYTE_W-1:0] RST_TRAILER   = 8'hCC;

  typedef struct packed {
    logic [DUR_W-1:0]  short_len;
    logic [DUR_W-1:0]  long_len;
    logic [DUR_W-1:0]  gap_len;
    logic [PRE_W-1:0]  pre_count;
    logic [BYTE_W-1:0] trailer;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              parity;
    logic [PRE_W-1:0]  pre_len;
  } frame_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/ppsf_front.sv
// front end: accepts packet bytes and classifies them into frame entries
// depends on ppsf_pkg
`default_nettype none

module ppsf_front (
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ppsf_pkg::BYTE_W-1:0] packet_byte_i,
  input  ppsf_pkg::cfg_t                   cfg_i,
  input  wire logic                        q_ready_i,
  output logic                             q_push_o,
  output ppsf_pkg::frame_entry_t           q_entry_o
);
  import ppsf_pkg::*;

  logic pre_over;

  assign pre_over   = cfg_i.pre_count > PRE_W'(MAX_PREAMBLE);
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i & q_ready_i;

  always_comb begin
    q_entry_o.data    = packet_byte_i;
    q_entry_o.parity  = ^packet_byte_i;
    // saturate preamble length
    q_entry_o.pre_len = pre_over ? PRE_W'(MAX_PREAMBLE) : cfg_i.pre_count;
  end

endmodule

`default_nettype wire

>>> rtl/core/ppsf_queue.sv
// short queue of frame entries between front and back
// depends on ppsf_pkg
`default_nettype none

module ppsf_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  ppsf_pkg::frame_entry_t entry_i,
  output logic                   ready_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output ppsf_pkg::frame_entry_t entry_o
);
  import ppsf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_entry_t     mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ppsf_back.sv
// back end: walks one frame entry symbol by symbol into the output register
// depends on ppsf_pkg
`default_nettype none

module ppsf_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  ppsf_pkg::cfg_t                   cfg_i,
  input  wire logic                        q_valid_i,
  input  ppsf_pkg::frame_entry_t           q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ppsf_pkg::KIND_W-1:0]      symbol_kind_o,
  output logic [ppsf_pkg::DUR_W-1:0]       duration_o,
  output logic                             last_symbol_o
);
  import ppsf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRE  = 5'b00010,
    ST_BITS = 5'b00100,
    ST_PAR  = 5'b01000,
    ST_GAP  = 5'b10000
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [PRE_W-1:0]  cnt_q, cnt_d;
  logic [PRE_W-1:0]  pre_len_q, pre_len_d;
  logic [BYTE_W-1:0] shreg_q, shreg_d;
  logic              par_q, par_d;
  logic              second_q, second_d;

  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] kind_q;
  logic [DUR_W-1:0]  dur_q;
  logic              last_q;

  logic              adv, emit;
  logic [KIND_W-1:0] sym_kind;
  logic              sym_last;
  logic [DUR_W-1:0]  sym_dur;

  assign adv = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pre_len_d = pre_len_q;
    shreg_d   = shreg_q;
    par_d     = par_q;
    second_d  = second_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    sym_kind  = KIND_LONG;
    sym_last  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          shreg_d   = q_entry_i.data;
          par_d     = q_entry_i.parity;
          pre_len_d = q_entry_i.pre_len;
          second_d  = 1'b0;
          cnt_d     = '0;
          state_d   = (q_entry_i.pre_len == '0) ? ST_BITS : ST_PRE;
        end
      end
      ST_PRE: begin
        emit     = adv;
        // alternating, long first
        sym_kind = cnt_q[0] ? KIND_SHORT : KIND_LONG;
        if (adv) begin
          if (cnt_q == pre_len_q - PRE_W'(1)) begin
            cnt_d   = '0;
            state_d = ST_BITS;
          end else begin
            cnt_d = cnt_q + PRE_W'(1);
          end
        end
      end
      ST_BITS: begin
        emit     = adv;
        sym_kind = shreg_q[BYTE_W-1] ? KIND_SHORT : KIND_LONG;
        if (adv) begin
          shreg_d = {shreg_q[BYTE_W-2:0], 1'b0};
          if (cnt_q == PRE_W'(BYTE_W - 1)) begin
            cnt_d   = '0;
            state_d = ST_PAR;
          end else begin
            cnt_d = cnt_q + PRE_W'(1);
          end
        end
      end
      ST_PAR: begin
        emit     = adv;
        sym_kind = par_q ? KIND_SHORT : KIND_LONG;
        if (adv) begin
          cnt_d   = '0;
          state_d = ST_GAP;
        end
      end
      ST_GAP: begin
        emit     = adv;
        sym_kind = KIND_GAP;
        sym_last = second_q && (cnt_q == PRE_W'(1));
        if (adv) begin
          if (cnt_q == '0) begin
            cnt_d = PRE_W'(1);
          end else if (!second_q) begin
            // trailer byte follows
            cnt_d    = '0;
            shreg_d  = cfg_i.trailer;
            par_d    = ^cfg_i.trailer;
            second_d = 1'b1;
            state_d  = ST_BITS;
          end else begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    case (sym_kind)
      KIND_SHORT: sym_dur = cfg_i.short_len;
      KIND_LONG:  sym_dur = cfg_i.long_len;
      default:    sym_dur = cfg_i.gap_len;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_len_q <= pre_len_d;
    shreg_q   <= shreg_d;
    par_q     <= par_d;
    if (emit) begin
      kind_q <= sym_kind;
      dur_q  <= sym_dur;
      last_q <= sym_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_kind_o = kind_q;
  assign duration_o    = dur_q;
  assign last_symbol_o = last_q;

endmodule

`default_nettype wire

>>> rtl/core/preamble_parity_symbol_framer_unit.sv
// channel   direction  signals
// cfg       in         cfg_valid_i cfg_ready_o cfg_index_i[2:0] cfg_data_i[19:0]
// in        in         in_valid_i in_ready_o packet_byte_i[7:0]
// out       out        out_valid_o out_ready_i symbol_kind_o[1:0] duration_o[19:0]
//                      last_symbol_o
//
// a byte makes a frame of p + 22 symbols, p the preamble count saturated at 32;
// the back end sends one symbol a cycle while its output is not stalled, and passes
// through its idle state to load each next entry, so the symbol sequencer sets the pace
// a two-word queue lets bytes be taken while the current frame is still going out
// a stalled output word holds the sequencer; the front stalls only on a full queue
// reset clears control state and loads the register reset values; no clearing pass
//
// top level of the preamble parity symbol framer
// depends on ppsf_pkg, ppsf_front, ppsf_queue, ppsf_back
`default_nettype none

module preamble_parity_symbol_framer_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ppsf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ppsf_pkg::DUR_W-1:0]     cfg_data_i,
  // packet bytes
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [ppsf_pkg::BYTE_W-1:0]    packet_byte_i,
  // symbols
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ppsf_pkg::KIND_W-1:0]         symbol_kind_o,
  output logic [ppsf_pkg::DUR_W-1:0]          duration_o,
  output logic                                last_symbol_o
);
  import ppsf_pkg::*;

  cfg_t         cfg_q, cfg_d;
  logic         q_push, q_ready, q_pop, q_valid;
  frame_entry_t q_in, q_out;

  // configuration registers, always ready; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SHORT_LEN: cfg_d.short_len = cfg_data_i;
        REG_LONG_LEN:  cfg_d.long_len  = cfg_data_i;
        REG_GAP_LEN:   cfg_d.gap_len   = cfg_data_i;
        REG_PRE_COUNT: cfg_d.pre_count = cfg_data_i[PRE_W-1:0];
        REG_TRAILER:   cfg_d.trailer   = cfg_data_i[BYTE_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_len <= RST_SHORT_LEN;
      cfg_q.long_len  <= RST_LONG_LEN;
      cfg_q.gap_len   <= RST_GAP_LEN;
      cfg_q.pre_count <= RST_PRE_COUNT;
      cfg_q.trailer   <= RST_TRAILER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: take byte, work out parity and preamble length
  ppsf_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .packet_byte_i (packet_byte_i),
    .cfg_i         (cfg_q),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  // decoupling queue
  ppsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  // back: symbol sequencer and output register
  ppsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_kind_o (symbol_kind_o),
    .duration_o    (duration_o),
    .last_symbol_o (last_symbol_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/ppsf_checker.sv
// port-level checker for the framer, bound to the top level
// depends on ppsf_pkg, assert_macros.svh, preamble_parity_symbol_framer_unit
`default_nettype none
`include "assert_macros.svh"

module ppsf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [ppsf_pkg::KIND_W-1:0] symbol_kind_o,
  input wire logic [ppsf_pkg::DUR_W-1:0]  duration_o,
  input wire logic                        last_symbol_o
);
  import ppsf_pkg::*;

  logic                     out_stall;
  logic                     out_fire;
  logic                     out_last;
  logic                     kind_bad;
  logic [KIND_W+DUR_W:0]    out_word;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_fire  = out_valid_o && out_ready_i;
  assign out_last  = out_valid_o && last_symbol_o;
  assign kind_bad  = out_valid_o && !(symbol_kind_o inside {KIND_LONG, KIND_SHORT, KIND_GAP});
  assign out_word  = {symbol_kind_o, duration_o, last_symbol_o};

  // stalled word holds
  `PPSF_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_word))

  // kind code is never the unused one
  `PPSF_NEVER(a_kind_code, clk_i, rst_ni, kind_bad)

  // a frame always closes on a gap
  `PPSF_ASSERT(a_last_gap, clk_i, rst_ni, out_last |-> symbol_kind_o == KIND_GAP)

  // a frame has many symbols, so two ends never follow each other
  `PPSF_ASSERT(a_last_spaced, clk_i, rst_ni, out_fire && last_symbol_o |=> !out_last)

endmodule

bind preamble_parity_symbol_framer_unit ppsf_checker u_ppsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .symbol_kind_o (symbol_kind_o),
  .duration_o    (duration_o),
  .last_symbol_o (last_symbol_o)
);

`default_nettype wire

>>> test/tb_preamble_parity_symbol_framer_unit.sv
// self-checking testbench of preamble_parity_symbol_framer_unit
// depends on ppsf_pkg and the framer rtl; predicts every symbol word and checks it in order
`timescale 1ns / 1ps

module tb_preamble_parity_symbol_framer_unit;
  import ppsf_pkg::*;

  // index codes that map to no register, writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LAST  = 3'd7;
  localparam logic [DUR_W-1:0]     DUR_MAX           = 20'hFFFFF;

  localparam int RANDOM_ITEMS = 391;
  // idle cycles after the last symbol before a register write or the end
  localparam int DRAIN_CYCLES = 40;
  // worst case is about 54 symbols per byte, each behind a long output stall, taken a few times over
  localparam int CYCLE_LIMIT  = 3000000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DUR_W-1:0]  dur;
    logic              last;
  } symbol_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DUR_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [BYTE_W-1:0]    packet_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [KIND_W-1:0]    symbol_kind_o;
  logic [DUR_W-1:0]     duration_o;
  logic                 last_symbol_o;

  // shadow copy of the register file
  cfg_t    shadow_cfg;
  // symbol words predicted but not yet seen on the output
  symbol_t pending_symbols[$];
  int      mismatch_count;
  int      cycle_count;
  // idling switches, flipped per phase so some stretches run with no gaps at all
  bit      in_gaps_on;
  bit      out_stalls_on;
  int      ready_hold;

  preamble_parity_symbol_framer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .packet_byte_i (packet_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_kind_o (symbol_kind_o),
    .duration_o    (duration_o),
    .last_symbol_o (last_symbol_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [DUR_W-1:0] duration_for(input logic [KIND_W-1:0] kind);
    if (kind == KIND_SHORT) begin
      return shadow_cfg.short_len;
    end else if (kind == KIND_LONG) begin
      return shadow_cfg.long_len;
    end
    return shadow_cfg.gap_len;
  endfunction

  function automatic void push_symbol(input logic [KIND_W-1:0] kind, input logic last);
    symbol_t s;
    s.kind = kind;
    s.dur  = duration_for(kind);
    s.last = last;
    pending_symbols.push_back(s);
  endfunction

  // eight bits msb first, even parity burst, two gap words
  function automatic void frame_bits(input logic [BYTE_W-1:0] value, input logic closes_frame);
    logic parity;
    parity = 1'b0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      parity ^= value[i];
      push_symbol(value[i] ? KIND_SHORT : KIND_LONG, 1'b0);
    end
    push_symbol(parity ? KIND_SHORT : KIND_LONG, 1'b0);
    push_symbol(KIND_GAP, 1'b0);
    // the second gap of the trailer ends the frame
    push_symbol(KIND_GAP, closes_frame);
  endfunction

  function automatic void frame_packet_byte(input logic [BYTE_W-1:0] value);
    int pre;
    pre = shadow_cfg.pre_count;
    // counts above the maximum saturate
    if (pre > MAX_PREAMBLE) begin
      pre = MAX_PREAMBLE;
    end
    // alternating preamble, long first
    for (int i = 0; i < pre; i++) begin
      push_symbol((i % 2 == 1) ? KIND_SHORT : KIND_LONG, 1'b0);
    end
    frame_bits(value, 1'b0);
    frame_bits(shadow_cfg.trailer, 1'b1);
  endfunction

  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [DUR_W-1:0] data);
    case (idx)
      REG_SHORT_LEN: shadow_cfg.short_len = data;
      REG_LONG_LEN:  shadow_cfg.long_len  = data;
      REG_GAP_LEN:   shadow_cfg.gap_len   = data;
      REG_PRE_COUNT: shadow_cfg.pre_count = data[PRE_W-1:0];
      REG_TRAILER:   shadow_cfg.trailer   = data[BYTE_W-1:0];
      // unknown index leaves every register as it was
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // idling helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 30);
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return '0;
    end else if (r < 16) begin
      return 20'd1;
    end else if (r < 24) begin
      return DUR_MAX;
    end
    return DUR_W'($urandom);
  endfunction

  // output side stall pattern, one nonblocking write per edge
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
      ready_hold  <= pick_gap() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    symbol_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch("unexpected symbol word, kind", symbol_kind_o, -1);
      end else begin
        want = pending_symbols.pop_front();
        if (symbol_kind_o !== want.kind) begin
          report_mismatch("symbol_kind", symbol_kind_o, want.kind);
        end
        if (duration_o !== want.dur) begin
          report_mismatch("duration", duration_o, want.dur);
        end
        if (last_symbol_o !== want.last) begin
          report_mismatch("last_symbol", last_symbol_o, want.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_symbols.size());
      $display("preamble_parity_symbol_framer_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // valid is left high when no gap follows, so the next byte goes out back to back
  task automatic offer_byte(input logic [BYTE_W-1:0] value);
    int gap;
    in_valid_i    <= 1'b1;
    packet_byte_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    frame_packet_byte(value);
    gap = (in_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i    <= 1'b0;
      packet_byte_i <= BYTE_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // same scheme as offer_byte, the caller drops valid after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_write(idx, data);
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
  endtask

  // sender holds off until every predicted word is out
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_symbols.size() != 0);
  endtask

  // block fully idle, safe for register writes
  task automatic settle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values, both parities and the bit extremes
  task automatic test_reset_values();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(8'h80);
    offer_byte(8'h01);
    offer_byte(8'hA5);
    offer_byte(8'h5B);
  endtask

  // no preamble, zero durations, all-zero trailer
  task automatic test_zero_preamble_and_durations();
    settle();
    write_reg(REG_SHORT_LEN, '0);
    write_reg(REG_LONG_LEN, '0);
    write_reg(REG_GAP_LEN, '0);
    write_reg(REG_PRE_COUNT, {14'h3FFF, 6'd0});
    write_reg(REG_TRAILER, {12'hFFF, 8'h00});
    end_writes();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(8'h7E);
    // one preamble word only
    settle();
    write_reg(REG_PRE_COUNT, 20'd1);
    write_reg(REG_SHORT_LEN, 20'd1);
    write_reg(REG_LONG_LEN, 20'd1);
    write_reg(REG_GAP_LEN, 20'd1);
    end_writes();
    offer_byte(8'h81);
    offer_byte(8'h3C);
  endtask

  // full preamble and counts beyond the maximum, widest durations
  task automatic test_preamble_saturation();
    settle();
    write_reg(REG_SHORT_LEN, DUR_MAX);
    write_reg(REG_LONG_LEN, DUR_MAX);
    write_reg(REG_GAP_LEN, DUR_MAX);
    write_reg(REG_TRAILER, 20'hFF);
    write_reg(REG_PRE_COUNT, 20'd32);
    end_writes();
    offer_byte(8'h55);
    offer_byte(8'hAA);
    settle();
    write_reg(REG_PRE_COUNT, 20'd33);
    end_writes();
    offer_byte(8'h0F);
    settle();
    write_reg(REG_PRE_COUNT, 20'd63);
    end_writes();
    offer_byte(8'hF0);
    offer_byte(8'h01);
  endtask

  // writes to unused indexes must not disturb any register
  task automatic test_unknown_index();
    settle();
    write_reg(REG_SHORT_LEN, 20'd17);
    write_reg(REG_LONG_LEN, 20'd99);
    write_reg(REG_GAP_LEN, 20'd5);
    write_reg(REG_PRE_COUNT, 20'd3);
    write_reg(REG_TRAILER, 20'h96);
    for (int idx = REG_UNKNOWN_FIRST; idx <= REG_UNKNOWN_LAST; idx++) begin
      write_reg(CFG_IDX_W'(idx), DUR_MAX);
    end
    end_writes();
    offer_byte(8'hC3);
    offer_byte(8'h24);
    offer_byte(8'hE7);
  endtask

  // random bytes in phases, each phase with its own register setting and idling mix
  task automatic test_random_traffic();
    int sent;
    int phase_len;
    int pre;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      // small preamble counts keep frames short, a few phases go to the top
      pre = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 12);
      write_reg(REG_SHORT_LEN, pick_duration());
      write_reg(REG_LONG_LEN, pick_duration());
      write_reg(REG_GAP_LEN, pick_duration());
      write_reg(REG_PRE_COUNT, {(DUR_W - PRE_W)'($urandom), PRE_W'(pre)});
      write_reg(REG_TRAILER, DUR_W'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_UNKNOWN_FIRST, REG_UNKNOWN_LAST)),
                  DUR_W'($urandom));
      end
      end_writes();
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 50);
      if (phase_len > RANDOM_ITEMS - sent) begin
        phase_len = RANDOM_ITEMS - sent;
      end
      for (int i = 0; i < phase_len; i++) begin
        offer_byte(BYTE_W'($urandom));
        sent++;
        if ($urandom_range(0, 59) == 0) begin
          hold_until_drained();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    packet_byte_i  = '0;
    out_ready_i    = 1'b0;
    ready_hold     = 0;
    in_gaps_on     = 1'b0;
    out_stalls_on  = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    shadow_cfg.short_len = RST_SHORT_LEN;
    shadow_cfg.long_len  = RST_LONG_LEN;
    shadow_cfg.gap_len   = RST_GAP_LEN;
    shadow_cfg.pre_count = RST_PRE_COUNT;
    shadow_cfg.trailer   = RST_TRAILER;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_zero_preamble_and_durations();
    test_preamble_saturation();
    test_unknown_index();
    test_random_traffic();

    settle();
    if (mismatch_count == 0) begin
      $display("preamble_parity_symbol_framer_unit regression: pass");
    end else begin
      $display("preamble_parity_symbol_framer_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> preamble_parity_symbol_framer_unit.f
+incdir+rtl/core
rtl/core/ppsf_pkg.sv
rtl/core/ppsf_front.sv
rtl/core/ppsf_queue.sv
rtl/core/ppsf_back.sv
rtl/core/preamble_parity_symbol_framer_unit.sv
rtl/core/ppsf_checker.sv
test/tb_preamble_parity_symbol_framer_unit.sv
